@@ hw/rtl/status_led_buzzer_pattern_sequencer_macros.svh @@
// Assertion macros shared by the sequencer RTL.
// Used by slbps_core and the top level; no other dependencies.
`ifndef STATUS_LED_BUZZER_PATTERN_SEQUENCER_MACROS_SVH
`define STATUS_LED_BUZZER_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SLBPS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slbps assertion failed");

// Next-cycle implication, disabled during reset
`define SLBPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slbps assertion failed");

`endif

@@ hw/rtl/slbps_pkg.sv @@
// Types and codes for the status LED / buzzer pattern sequencer.
// No dependencies; used by the interfaces, slbps_core and the top level.
package slbps_pkg;

   // Alert pattern codes
   localparam logic [2:0] PAT_NONE      = 3'd0;
   localparam logic [2:0] PAT_STARTING  = 3'd1;
   localparam logic [2:0] PAT_STARTED   = 3'd2;
   localparam logic [2:0] PAT_OVERSPEED = 3'd3;
   localparam logic [2:0] PAT_OVERTIME  = 3'd4;
   localparam logic [2:0] PAT_LOGIN     = 3'd5;
   localparam logic [2:0] PAT_LOGOUT    = 3'd6;

   // Two-state status codes; other codes leave the output alone, except GPS in low power
   localparam logic [1:0] ST_OFF = 2'd0;
   localparam logic [1:0] ST_ON  = 2'd1;

   typedef struct packed {
      logic       action;
      logic [2:0] alert_pattern;
      logic [1:0] link_status;
      logic       sim_missing;
      logic       internet_up;
      logic [1:0] gps_fix;
      logic       low_power;
      logic [1:0] drv_login;
      logic [1:0] hiring_request;
      logic       test_hold;
   } req_type;

   typedef struct packed {
      logic       led_link;
      logic       led_gps;
      logic       led_drv;
      logic       buzzer_on;
      logic       power_out;
      logic       hiring_flag;
      logic [2:0] active_pattern;
   } rsp_type;

   // Control from the pipeline to the core
   typedef struct packed {
      logic step;
      logic csr_wr_en;
      logic csr_wr_data;
   } ctl_type;

endpackage

@@ hw/rtl/slbps_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on slbps_pkg for the payload types.
interface slbps_req_if import slbps_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface slbps_rsp_if import slbps_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/slbps_core.sv @@
// Sequencer state (phase counters, pattern, output levels) and next-state logic.
// Depends on slbps_pkg and the assertion macro header.
`include "status_led_buzzer_pattern_sequencer_macros.svh"

module slbps_core import slbps_pkg::*; #(
   parameter int LONG_PERIOD_MAX = 80
) (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   input  req_type req,
   output rsp_type rsp
);

   localparam int LW = $clog2(LONG_PERIOD_MAX + 1);

   logic          buzzer_enable_ff, buzzer_enable_in;
   logic [2:0]    led_phase_ff, led_phase_in;
   logic [2:0]    buzz_phase_ff, buzz_phase_in;
   logic [LW-1:0] long_phase_ff, long_phase_in;
   logic [2:0]    long_mod7_ff, long_mod7_in;   // long_phase modulo 7
   logic [2:0]    pattern_ff, pattern_in;
   logic          lv_link_ff, lv_link_in;
   logic          lv_gps_ff, lv_gps_in;
   logic          lv_driver_ff, lv_driver_in;
   logic          lv_buzz_ff, lv_buzz_in;
   logic          lv_power_ff, lv_power_in;
   logic          lv_hire_ff, lv_hire_in;
   logic [LW:0]   long_next;
   logic          even;

   // Next state for one request
   always_comb begin
      buzzer_enable_in = ctl.csr_wr_en ? ctl.csr_wr_data : buzzer_enable_ff;
      led_phase_in     = led_phase_ff;
      buzz_phase_in    = buzz_phase_ff;
      long_phase_in    = long_phase_ff;
      long_mod7_in     = long_mod7_ff;
      pattern_in       = pattern_ff;
      lv_link_in       = lv_link_ff;
      lv_gps_in        = lv_gps_ff;
      lv_driver_in     = lv_driver_ff;
      lv_buzz_in       = lv_buzz_ff;
      lv_power_in      = lv_power_ff;
      lv_hire_in       = lv_hire_ff;
      even             = ~led_phase_ff[0];
      long_next        = {1'b0, long_phase_ff} + (LW+1)'(1);

      if (ctl.step) begin
         if (req.action) begin
            // load a new alert pattern, restart the short buzzer phase
            pattern_in    = req.alert_pattern;
            buzz_phase_in = 3'd0;
         end else begin
            // power out and hiring flag
            if (req.hiring_request == ST_OFF) begin
               lv_power_in = 1'b0;
               lv_hire_in  = 1'b0;
            end else if (req.hiring_request == ST_ON) begin
               lv_power_in = 1'b1;
               lv_hire_in  = 1'b1;
            end

            // link LED
            if (req.link_status == ST_OFF) begin
               if (req.sim_missing) begin
                  lv_link_in = (long_phase_ff == LW'(0)) || (long_phase_ff == LW'(2));
               end else if (req.internet_up) begin
                  lv_link_in = 1'b1;
               end else begin
                  lv_link_in = (long_phase_ff == LW'(0)) || (long_phase_ff == LW'(2)) ||
                               (long_phase_ff == LW'(4));
               end
            end else if (req.link_status == ST_ON) begin
               lv_link_in = even;
            end

            // GPS LED
            if (req.low_power) begin
               lv_gps_in = (req.gps_fix == ST_ON) && (led_phase_ff == 3'd1);
            end else if (req.gps_fix == ST_ON) begin
               lv_gps_in = even;
            end else if (req.gps_fix == ST_OFF) begin
               lv_gps_in = 1'b1;
            end

            // driver LED
            if (req.drv_login == ST_OFF) begin
               lv_driver_in = 1'b1;
            end else if (req.drv_login == ST_ON) begin
               lv_driver_in = even;
            end

            // buzzer pattern
            if (buzzer_enable_ff) begin
               unique case (pattern_ff)
                  PAT_NONE: begin
                     if (!req.test_hold) lv_buzz_in = 1'b0;
                  end
                  PAT_STARTING, PAT_LOGIN: begin
                     if (buzz_phase_ff <= 3'd2) begin
                        lv_buzz_in = 1'b1;
                     end else if (buzz_phase_ff == 3'd3) begin
                        lv_buzz_in = 1'b0;
                        pattern_in = PAT_NONE;
                     end
                  end
                  PAT_STARTED: begin
                     if (buzz_phase_ff <= 3'd2) begin
                        lv_buzz_in = ~buzz_phase_ff[0];
                     end else if (buzz_phase_ff == 3'd3) begin
                        lv_buzz_in = 1'b0;
                        pattern_in = PAT_NONE;
                     end
                  end
                  PAT_OVERSPEED: lv_buzz_in = (long_mod7_ff == 3'd0);
                  PAT_OVERTIME: begin
                     lv_buzz_in = ({1'b0, long_phase_ff} <= (LW+1)'(6)) && !long_phase_ff[0];
                  end
                  PAT_LOGOUT: begin
                     if (buzz_phase_ff <= 3'd4) begin
                        lv_buzz_in = ~buzz_phase_ff[0];
                     end else if (buzz_phase_ff == 3'd5) begin
                        lv_buzz_in = 1'b0;
                        pattern_in = PAT_NONE;
                     end
                  end
                  default: ;  // unused code seven: no buzzer action
               endcase
            end

            // phase counters
            led_phase_in  = led_phase_ff + 3'd1;
            buzz_phase_in = buzz_phase_ff + 3'd1;
            if (long_next > (LW+1)'(LONG_PERIOD_MAX)) begin
               long_phase_in = '0;
               long_mod7_in  = 3'd0;
            end else begin
               long_phase_in = long_next[LW-1:0];
               long_mod7_in  = (long_mod7_ff == 3'd6) ? 3'd0 : long_mod7_ff + 3'd1;
            end
         end
      end
   end

   // Result fields: levels after this request
   assign rsp.led_link       = lv_link_in;
   assign rsp.led_gps        = lv_gps_in;
   assign rsp.led_drv        = lv_driver_in;
   assign rsp.buzzer_on      = lv_buzz_in;
   assign rsp.power_out      = lv_power_in;
   assign rsp.hiring_flag    = lv_hire_in;
   assign rsp.active_pattern = pattern_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buzzer_enable_ff <= 1'b1;
         led_phase_ff     <= 3'd0;
         buzz_phase_ff    <= 3'd0;
         long_phase_ff    <= '0;
         long_mod7_ff     <= 3'd0;
         pattern_ff       <= PAT_NONE;
         lv_link_ff       <= 1'b1;
         lv_gps_ff        <= 1'b1;
         lv_driver_ff     <= 1'b1;
         lv_buzz_ff       <= 1'b0;
         lv_power_ff      <= 1'b0;
         lv_hire_ff       <= 1'b0;
      end else begin
         buzzer_enable_ff <= buzzer_enable_in;
         led_phase_ff     <= led_phase_in;
         buzz_phase_ff    <= buzz_phase_in;
         long_phase_ff    <= long_phase_in;
         long_mod7_ff     <= long_mod7_in;
         pattern_ff       <= pattern_in;
         lv_link_ff       <= lv_link_in;
         lv_gps_ff        <= lv_gps_in;
         lv_driver_ff     <= lv_driver_in;
         lv_buzz_ff       <= lv_buzz_in;
         lv_power_ff      <= lv_power_in;
         lv_hire_ff       <= lv_hire_in;
      end
   end

   `SLBPS_ASSERT_IMPLIES(a_long_range, clock, reset, 1'b1, long_phase_ff <= LW'(LONG_PERIOD_MAX))
   `SLBPS_ASSERT_IMPLIES(a_mod7_at_wrap, clock, reset, long_phase_ff == '0, long_mod7_ff == 3'd0)
   `SLBPS_ASSERT_NEXT(a_load_restarts, clock, reset, ctl.step && req.action, buzz_phase_ff == 3'd0)
   `SLBPS_ASSERT_NEXT(a_hire_pairs, clock, reset, 1'b1, lv_power_ff == lv_hire_ff)

endmodule

@@ hw/rtl/status_led_buzzer_pattern_sequencer.sv @@
// Top level of the status LED / buzzer pattern sequencer: request register,
// result register and the sequencer core. Depends on slbps_pkg, slbps_if,
// slbps_core and the assertion macro header.
//
// Usage:
//   req_chan carries one request per valid/ready handshake: a tick (action 0)
//   that updates LEDs, buzzer, power out and hiring flag and advances the phase
//   counters, or a load (action 1) that selects a new alert pattern.
//   rsp_chan returns exactly one result per request, in order: the output
//   levels and the active pattern after that request.
//   csr_wr_en / csr_wr_data write the buzzer enable bit; write only when idle.
// Path: request register, then result register; the core state updates as
//   the result register loads.
// Throughput: one request per cycle while rsp_chan.ready is high.
// Reset: synchronous, active high. Phases and pattern clear, LEDs on, buzzer,
//   power out and hiring flag off, buzzer enable set. Both registers empty.
// Stall: if rsp_chan.ready is low the result register holds; the request
//   register still takes one more request, then req_chan.ready drops.
`include "status_led_buzzer_pattern_sequencer_macros.svh"

module status_led_buzzer_pattern_sequencer import slbps_pkg::*; #(
   parameter int LONG_PERIOD_MAX = 80
) (
   input logic         clock,
   input logic         reset,
   slbps_req_if.sink   req_chan,
   slbps_rsp_if.source rsp_chan,
   input logic         csr_wr_en,
   input logic         csr_wr_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   ctl_type core_ctl;
   logic    s1_adv;
   logic    req_take;

   // Handshake control
   assign s1_adv            = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready    = !s1_valid_ff || s1_adv;
   assign req_take          = req_chan.valid && req_chan.ready;
   assign s1_valid_in       = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in      = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   assign core_ctl.step        = s1_adv;
   assign core_ctl.csr_wr_en   = csr_wr_en;
   assign core_ctl.csr_wr_data = csr_wr_data;

   slbps_core #(
      .LONG_PERIOD_MAX(LONG_PERIOD_MAX)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .req   (s1_data_ff),
      .rsp   (core_rsp)
   );

   // Request and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) s1_data_ff <= req_chan.data;
      if (s1_adv) out_data_ff <= core_rsp;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   `SLBPS_ASSERT_IMPLIES(a_rsp_from_step, clock, reset, $rose(out_valid_ff), $past(s1_adv))
   `SLBPS_ASSERT_IMPLIES(a_full_blocks, clock, reset, s1_valid_ff && !s1_adv, !req_chan.ready)
   `SLBPS_ASSERT_IMPLIES(a_empty_out_drains, clock, reset, s1_valid_ff && !out_valid_ff, s1_adv)

endmodule

@@ tb/sv/status_led_buzzer_pattern_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the status LED / buzzer pattern sequencer: random and directed
// requests, an in-bench predictor of the output levels, and in-order result checks.
// Depends on slbps_pkg, slbps_if and the sequencer RTL.
module status_led_buzzer_pattern_sequencer_tb;
   import slbps_pkg::*;

   localparam int LONG_WRAP   = 80;      // long phase counts 0..LONG_WRAP
   localparam int RESET_TICKS = 9;
   localparam int SETTLE      = 6;       // two-stage latency plus margin
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF    = 150;     // long receiver stall, in cycles

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   slbps_req_if req_chan ();
   slbps_rsp_if rsp_chan ();

   status_led_buzzer_pattern_sequencer #(
      .LONG_PERIOD_MAX(LONG_WRAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Bench state
   req_type pending_reqs[$];
   rsp_type levels_due[$];
   int      req_idle_pct;
   int      rsp_idle_pct;
   logic    hold_off_go;
   logic    hold_seen;
   int      hold_left;
   int      mismatches;
   int      results_seen;
   int      ticks_sent;
   int      loads_sent;
   int      cycle_count;
   rsp_type got_rsp;
   rsp_type want_rsp;

   // Predictor state
   logic       buzz_en_m;
   logic [2:0] led_ph_m;
   logic [2:0] buzz_ph_m;
   logic [6:0] long_ph_m;
   logic [2:0] pat_m;
   logic       lv_link, lv_gps, lv_driver, lv_buzz, lv_power, lv_hire;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_predictor();
      buzz_en_m = 1'b1;
      led_ph_m  = '0;
      buzz_ph_m = '0;
      long_ph_m = '0;
      pat_m     = PAT_NONE;
      lv_link   = 1'b1;
      lv_gps    = 1'b1;
      lv_driver = 1'b1;
      lv_buzz   = 1'b0;
      lv_power  = 1'b0;
      lv_hire   = 1'b0;
   endfunction

   // Buzzer level from the active alert pattern; one-shots drop back to none
   function automatic void step_buzzer(logic ir_test);
      case (pat_m)
         PAT_NONE: if (!ir_test) lv_buzz = 1'b0;
         PAT_STARTING, PAT_LOGIN: begin
            if (buzz_ph_m <= 3'd2) lv_buzz = 1'b1;
            else if (buzz_ph_m == 3'd3) begin
               lv_buzz = 1'b0;
               pat_m   = PAT_NONE;
            end
         end
         PAT_STARTED: begin
            if (buzz_ph_m <= 3'd2) lv_buzz = ~buzz_ph_m[0];
            else if (buzz_ph_m == 3'd3) begin
               lv_buzz = 1'b0;
               pat_m   = PAT_NONE;
            end
         end
         PAT_OVERSPEED: lv_buzz = ((long_ph_m % 7) == 0);
         PAT_OVERTIME:  lv_buzz = (long_ph_m <= 7'd6) && !long_ph_m[0];
         PAT_LOGOUT: begin
            if (buzz_ph_m <= 3'd4) lv_buzz = ~buzz_ph_m[0];
            else if (buzz_ph_m == 3'd5) begin
               lv_buzz = 1'b0;
               pat_m   = PAT_NONE;
            end
         end
         default: ;  // unused code seven: buzzer holds
      endcase
   endfunction

   // Advance the predictor by one request and return the levels it leaves
   function automatic rsp_type predict_status(req_type r);
      logic    even;
      rsp_type o;
      if (r.action) begin
         pat_m     = r.alert_pattern;
         buzz_ph_m = '0;
      end else begin
         even = ~led_ph_m[0];
         case (r.hiring_request)
            ST_OFF: begin lv_power = 1'b0; lv_hire = 1'b0; end
            ST_ON:  begin lv_power = 1'b1; lv_hire = 1'b1; end
            default: ;
         endcase
         case (r.link_status)
            ST_OFF: begin
               if (r.sim_missing)
                  lv_link = (long_ph_m == 7'd0) || (long_ph_m == 7'd2);
               else if (r.internet_up)
                  lv_link = 1'b1;
               else
                  lv_link = (long_ph_m == 7'd0) || (long_ph_m == 7'd2) || (long_ph_m == 7'd4);
            end
            ST_ON: lv_link = even;
            default: ;
         endcase
         if (r.low_power)           lv_gps = (r.gps_fix == ST_ON) && (led_ph_m == 3'd1);
         else if (r.gps_fix == ST_ON)  lv_gps = even;
         else if (r.gps_fix == ST_OFF) lv_gps = 1'b1;
         if (r.drv_login == ST_OFF)     lv_driver = 1'b1;
         else if (r.drv_login == ST_ON) lv_driver = even;
         if (buzz_en_m) step_buzzer(r.test_hold);
         led_ph_m  = led_ph_m + 3'd1;
         buzz_ph_m = buzz_ph_m + 3'd1;
         long_ph_m = (long_ph_m >= LONG_WRAP) ? 7'd0 : long_ph_m + 7'd1;
      end
      o.led_link       = lv_link;
      o.led_gps        = lv_gps;
      o.led_drv        = lv_driver;
      o.buzzer_on      = lv_buzz;
      o.power_out      = lv_power;
      o.hiring_flag    = lv_hire;
      o.active_pattern = pat_m;
      return o;
   endfunction

   // Mostly clean 0/1 status codes, now and then the unused ones
   function automatic logic [1:0] status_code();
      if ($urandom_range(7) == 0) return 2'($urandom_range(3));
      return 2'($urandom_range(1));
   endfunction

   function automatic req_type tick_req();
      req_type r;
      r.action         = 1'b0;
      r.alert_pattern  = 3'($urandom_range(7));
      r.link_status    = status_code();
      r.sim_missing    = 1'($urandom_range(1));
      r.internet_up    = 1'($urandom_range(1));
      r.gps_fix        = status_code();
      r.low_power      = 1'($urandom_range(1));
      r.drv_login      = status_code();
      r.hiring_request = status_code();
      r.test_hold      = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type load_req(logic [2:0] pat);
      req_type r;
      r               = 16'($urandom());
      r.action        = 1'b1;
      r.alert_pattern = pat;
      return r;
   endfunction

   function automatic req_type fixed_tick(logic [1:0] link, logic sim, logic inet,
                                          logic [1:0] gps, logic psave, logic [1:0] login,
                                          logic [1:0] hire, logic irt);
      req_type r;
      r.action         = 1'b0;
      r.alert_pattern  = PAT_NONE;
      r.link_status    = link;
      r.sim_missing    = sim;
      r.internet_up    = inet;
      r.gps_fix        = gps;
      r.low_power      = psave;
      r.drv_login      = login;
      r.hiring_request = hire;
      r.test_hold      = irt;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            levels_due.push_back(predict_status(req_chan.data));
            if (req_chan.data.action) loads_sent++;
            else ticks_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               req_chan.data  <= pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once from the stimulus
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_off_go && !hold_seen) begin
         hold_left <= HOLD_OFF;
         hold_seen <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            got_rsp = rsp_chan.data;
            if (levels_due.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want_rsp = levels_due.pop_front();
               check_field("led_link", got_rsp.led_link, want_rsp.led_link);
               check_field("led_gps", got_rsp.led_gps, want_rsp.led_gps);
               check_field("led_drv", got_rsp.led_drv, want_rsp.led_drv);
               check_field("buzzer_on", got_rsp.buzzer_on, want_rsp.buzzer_on);
               check_field("power_out", got_rsp.power_out, want_rsp.power_out);
               check_field("hiring_flag", got_rsp.hiring_flag, want_rsp.hiring_flag);
               check_field("active_pattern", got_rsp.active_pattern,
                           want_rsp.active_pattern);
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, levels_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Wait until every request is sent and answered, then let the pipe settle
   task automatic drain();
      while (pending_reqs.size() > 0 || req_chan.valid || levels_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_buzzer_enable(logic value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      buzz_en_m    = value;
   endtask

   task automatic set_idling(int req_pct, int rsp_pct);
      @(posedge clock);
      req_idle_pct <= req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   // Pattern loads followed by tick runs, mixed with raw noise requests
   task automatic queue_traffic(int count);
      int n;
      int run;
      logic [2:0] pat;
      n = 0;
      while (n < count) begin
         run = $urandom_range(14, 2);
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(9) < 8) pat = 3'($urandom_range(6, 1));
            else pat = $urandom_range(1) ? 3'd7 : PAT_NONE;
            pending_reqs.push_back(load_req(pat));
            repeat (run) pending_reqs.push_back(tick_req());
         end else begin
            repeat (run) pending_reqs.push_back(req_type'(16'($urandom())));
         end
         n += run + 1;
      end
   endtask

   // Directed corners: status extremes, every alert pattern including code seven
   task automatic queue_directed();
      pending_reqs.push_back(fixed_tick(2'd0, 1'b0, 1'b0, 2'd0, 1'b0, 2'd0, 2'd0, 1'b0));
      pending_reqs.push_back(fixed_tick(2'd3, 1'b1, 1'b1, 2'd3, 1'b1, 2'd3, 2'd3, 1'b1));
      pending_reqs.push_back(fixed_tick(2'd0, 1'b1, 1'b1, 2'd1, 1'b1, 2'd1, 2'd1, 1'b0));
      pending_reqs.push_back(fixed_tick(2'd0, 1'b0, 1'b1, 2'd0, 1'b1, 2'd2, 2'd2, 1'b1));
      pending_reqs.push_back(fixed_tick(2'd0, 1'b0, 1'b0, 2'd1, 1'b0, 2'd1, 2'd0, 1'b0));
      pending_reqs.push_back(fixed_tick(2'd1, 1'b0, 1'b0, 2'd2, 1'b0, 2'd0, 2'd1, 1'b1));
      for (int p = 0; p < 8; p++) begin
         pending_reqs.push_back(load_req(3'(p)));
         pending_reqs.push_back(tick_req());
      end
      pending_reqs.push_back(fixed_tick(2'd2, 1'b0, 1'b0, 2'd2, 1'b0, 2'd3, 2'd3, 1'b1));
   endtask

   // Main sequence
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      hold_off_go    = 1'b0;
      req_idle_pct   = 0;
      rsp_idle_pct   = 0;
      mismatches     = 0;
      results_seen   = 0;
      ticks_sent     = 0;
      loads_sent     = 0;
      cycle_count    = 0;
      clear_predictor();
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // Buzzer on, sender idles less than receiver
      write_buzzer_enable(1'b1);
      set_idling(34, 58);
      queue_directed();
      queue_traffic(620);
      drain();

      // Buzzer logic skipped, idling swapped
      write_buzzer_enable(1'b0);
      set_idling(58, 34);
      queue_traffic(630);
      drain();

      // Buzzer back on, full rate, one long receiver stall under load
      write_buzzer_enable(1'b1);
      set_idling(0, 0);
      queue_traffic(630);
      @(posedge clock);
      hold_off_go <= 1'b1;
      drain();

      $display("Covered %0d ticks and %0d pattern loads, %0d results checked,",
               ticks_sent, loads_sent, results_seen);
      $display("with buzzer enable on and off, both idling mixes and a long stall.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
